>>> rtl/psba_pkg.sv
// shared constants and types of the page slot bitmap allocator
`timescale 1ns / 1ps
package psba_pkg;

  localparam int MAX_SLOTS  = 512;
  localparam int PAGE_BYTES = 4096;

  // bitmap organisation: one memory row holds WORD_W slot bits
  localparam int WORD_W = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
  localparam int ROWS   = MAX_SLOTS / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int SLOT_W = $clog2(MAX_SLOTS);

  // field widths
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 10;
  localparam int STAT_W     = 2;
  localparam int SNUM_W     = 9;
  localparam int BOFF_W     = 12;
  localparam int CNT_W      = 10;
  localparam int SIZE_W     = 12;
  localparam int START_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // limit compare width covers both the slot count field and MAX_SLOTS
  localparam int LIM_W = ($clog2(MAX_SLOTS + 1) > CNT_W) ? $clog2(MAX_SLOTS + 1) : CNT_W;
  // offset arithmetic width before page wrap
  localparam int OFF_W = SIZE_W + SLOT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOCATE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_COUNT    = 2'd0,
    CFG_RECORD_SIZE   = 2'd1,
    CFG_RECORDS_START = 2'd2
  } cfg_idx_t;

endpackage

>>> rtl/psba_in_if.sv
// request channel: operation kind and slot index
`timescale 1ns / 1ps
interface psba_in_if;
  import psba_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  slot_index;

  modport source (output valid, output kind, output slot_index, input ready);
  modport sink   (input valid, input kind, input slot_index, output ready);
endinterface

>>> rtl/psba_out_if.sv
// result channel: status, slot number and byte offset
`timescale 1ns / 1ps
interface psba_out_if;
  import psba_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SNUM_W-1:0] slot_number;
  logic [BOFF_W-1:0] byte_offset;

  modport source (output valid, output status, output slot_number, output byte_offset,
                  input ready);
  modport sink   (input valid, input status, input slot_number, input byte_offset,
                  output ready);
endinterface

>>> rtl/page_slot_bitmap_allocator_unit.sv
// top level of the page slot bitmap allocator
`timescale 1ns / 1ps
// usage
//   in_chan carries one request beat: kind (allocate, free, locate, clear all)
//   and slot_index. out_chan returns exactly one result beat per request:
//   status, slot_number and byte_offset.
//   cfg_we/cfg_index/cfg_data write slot_count, record_size and records_start;
//   write them only while no request is in flight.
// timing
//   a request is taken only in the idle state. the bitmap row is read on the
//   accepting edge and modified and written back in the eval state; the offset
//   multiply follows in the mul state and the result register loads in the
//   load state, once out ready allows. a new request is taken only after the
//   result has loaded; the read-modify-write of the bitmap ram sets this order.
// reset
//   the bitmap is cleared at once through per-row valid flags (and clear all
//   does the same), so there is no clearing pass. control and config registers reset to zero.
// stall
//   a waiting result sits in the output register; one further request can be
//   taken and worked up to the output load, which then waits for out ready.
module page_slot_bitmap_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  psba_in_if.sink                           in_chan,
  psba_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [psba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psba_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import psba_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_MUL, S_LOAD} state_t;

  localparam logic [OFF_W-1:0] PAGE_MASK = OFF_W'(PAGE_BYTES - 1);

  state_t state_r;

  // configuration registers
  logic [CNT_W-1:0]   slot_count_r;
  logic [SIZE_W-1:0]  record_size_r;
  logic [START_W-1:0] records_start_r;

  // per-row summary: row holds written data, row is completely used
  logic [ROWS-1:0] row_valid_r;
  logic [ROWS-1:0] row_full_r;

  // request held while in flight
  kind_t            kind_r;
  logic [IDX_W-1:0] idx_r;
  logic [ROW_W-1:0] row_r;
  logic             any_free_r;

  // evaluated result
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_zero_r;
  logic [OFF_W-1:0]  prod_r;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [SNUM_W-1:0] out_slot_r;
  logic [BOFF_W-1:0] out_off_r;

  logic in_acc;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // usable limit, slot counts above MAX_SLOTS act as MAX_SLOTS
  logic [LIM_W-1:0] limit;
  always_comb begin
    if (LIM_W'(slot_count_r) > LIM_W'(MAX_SLOTS)) begin
      limit = LIM_W'(MAX_SLOTS);
    end else begin
      limit = LIM_W'(slot_count_r);
    end
  end

  // lowest row that still has a free bit
  logic [ROW_W-1:0] free_row;
  logic             any_free;
  always_comb begin
    free_row = '0;
    any_free = 1'b0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!row_full_r[i]) begin
        free_row = ROW_W'(i);
        any_free = 1'b1;
      end
    end
  end

  logic [ROW_W-1:0] rd_addr;
  assign rd_addr = (kind_t'(in_chan.kind) == KIND_ALLOC) ? free_row
                                                        : ROW_W'(in_chan.slot_index >> BIT_W);

  // bitmap memory
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  psba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (row_r),
    .wr_data (ram_wdata),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // evaluation of the fetched row
  logic [WORD_W-1:0] word;
  logic [LIM_W-1:0]  row_base;
  logic [WORD_W-1:0] beyond;
  logic [WORD_W-1:0] avail;
  logic [BIT_W-1:0]  first_bit;
  logic              found;
  logic [BIT_W-1:0]  sel_bit;
  logic [WORD_W-1:0] alloc_hot;
  logic [WORD_W-1:0] sel_hot;
  logic              idx_out_of_range;

  assign word     = row_valid_r[row_r] ? ram_rdata : '0;
  assign row_base = LIM_W'(row_r) << BIT_W;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      beyond[b] = (row_base + LIM_W'(b)) >= limit;
    end
  end

  assign avail = ~(word | beyond);

  always_comb begin
    first_bit = '0;
    found     = 1'b0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        first_bit = BIT_W'(b);
        found     = 1'b1;
      end
    end
  end

  assign sel_bit          = BIT_W'(idx_r);
  assign alloc_hot        = WORD_W'(1) << first_bit;
  assign sel_hot          = WORD_W'(1) << sel_bit;
  assign idx_out_of_range = LIM_W'(idx_r) >= limit;

  status_t           ev_status;
  logic [SLOT_W-1:0] ev_slot;
  logic              ev_zero;
  logic              ev_we;
  logic [WORD_W-1:0] ev_wdata;
  logic              ev_full;

  always_comb begin
    ev_status = ST_OK;
    ev_slot   = '0;
    ev_zero   = 1'b1;
    ev_we     = 1'b0;
    ev_wdata  = word;
    ev_full   = 1'b0;
    case (kind_r)
      KIND_ALLOC: begin
        if (!any_free_r || !found) begin
          ev_status = ST_FULL;
        end else begin
          ev_slot  = (SLOT_W'(row_r) << BIT_W) | SLOT_W'(first_bit);
          ev_zero  = 1'b0;
          ev_we    = 1'b1;
          ev_wdata = word | alloc_hot;
          ev_full  = &(word | alloc_hot);
        end
      end
      KIND_FREE, KIND_LOCATE: begin
        if (idx_out_of_range) begin
          ev_status = ST_RANGE;
        end else if (!word[sel_bit]) begin
          ev_status = ST_UNUSED;
        end else begin
          ev_slot  = SLOT_W'(idx_r);
          ev_zero  = 1'b0;
          ev_we    = (kind_r == KIND_FREE);
          ev_wdata = word & ~sel_hot;
        end
      end
      default: begin
        // clear all: ok with zero slot and offset
        ev_status = ST_OK;
      end
    endcase
  end

  assign ram_we    = (state_r == S_EVAL) && ev_we;
  assign ram_wdata = ev_wdata;

  // offset after page wrap, kept to the field width
  logic [OFF_W-1:0] off_sum;
  logic [OFF_W-1:0] off_page;
  assign off_sum  = OFF_W'(records_start_r) + prod_r;
  assign off_page = off_sum & PAGE_MASK;

  logic out_load;
  assign out_load = (state_r == S_LOAD) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      row_valid_r     <= '0;
      row_full_r      <= '0;
      slot_count_r    <= '0;
      record_size_r   <= '0;
      records_start_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SLOT_COUNT:    slot_count_r    <= CNT_W'(cfg_data);
          CFG_RECORD_SIZE:   record_size_r   <= SIZE_W'(cfg_data);
          CFG_RECORDS_START: records_start_r <= START_W'(cfg_data);
          default: ;
        endcase
      end

      // a new load wins over the beat leaving in the same cycle
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            kind_r     <= kind_t'(in_chan.kind);
            idx_r      <= in_chan.slot_index;
            row_r      <= rd_addr;
            any_free_r <= any_free;
            state_r    <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_status_r <= ev_status;
          res_slot_r   <= ev_slot;
          res_zero_r   <= ev_zero;
          if (kind_r == KIND_CLEAR) begin
            row_valid_r <= '0;
            row_full_r  <= '0;
          end else if (ev_we) begin
            row_valid_r[row_r] <= 1'b1;
            row_full_r[row_r]  <= ev_full;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= OFF_W'(record_size_r) * OFF_W'(res_slot_r);
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (out_load) begin
            out_status_r <= res_status_r;
            out_slot_r   <= SNUM_W'(res_slot_r);
            out_off_r    <= res_zero_r ? '0 : off_page[BOFF_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.slot_number = out_slot_r;
  assign out_chan.byte_offset = out_off_r;

endmodule

>>> rtl/psba_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module psba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

>>> sim/tb.sv
// self-checking testbench of the page slot bitmap allocator
`timescale 1ns / 1ps
module tb;
  import psba_pkg::*;

  // run limits and timing
  localparam int unsigned CYCLE_LIMIT       = 500_000;
  localparam int unsigned DRAIN_CYCLES      = 6;    // settling time after every owed result has come back
  localparam int unsigned LONG_STALL_AT     = 300;  // results seen before the long hold-off
  localparam int unsigned LONG_STALL_CYCLES = 400;
  localparam int unsigned MAX_REPORTS       = 50;
  localparam int unsigned IDX_TOP           = (1 << IDX_W) - 1;

  // index beyond the register list, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // one expected result beat
  typedef struct {
    status_t           status;
    logic [SNUM_W-1:0] slot_number;
    logic [BOFF_W-1:0] byte_offset;
  } slot_result_t;

  // predicts the allocator and holds the results still owed by the block
  class slot_map_scoreboard;
    logic [MAX_SLOTS-1:0] used_slots;
    logic [CNT_W-1:0]     slot_count;
    logic [SIZE_W-1:0]    record_size;
    logic [START_W-1:0]   records_start;
    slot_result_t         pending_results[$];
    int unsigned          mismatches;
    int unsigned          results_checked;

    function new();
      used_slots      = '0;
      slot_count      = '0;
      record_size     = '0;
      records_start   = '0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SLOT_COUNT:    slot_count    = data[CNT_W-1:0];
        CFG_RECORD_SIZE:   record_size   = data[SIZE_W-1:0];
        CFG_RECORDS_START: records_start = data[START_W-1:0];
        default: ;
      endcase
    endfunction

    // counts above the page capacity behave as the capacity
    function int unsigned usable_limit();
      return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
    endfunction

    function logic [BOFF_W-1:0] slot_offset(int unsigned slot);
      logic [31:0] sum;
      sum = records_start + record_size * slot;
      sum = sum % PAGE_BYTES;
      return sum[BOFF_W-1:0];
    endfunction

    // works out the result of one accepted request and updates the map
    function void note_request(kind_t kind, logic [IDX_W-1:0] idx);
      slot_result_t res;
      int unsigned  lim;
      bit           found;
      res   = '{ST_OK, '0, '0};
      lim   = usable_limit();
      found = 1'b0;
      case (kind)
        KIND_ALLOC: begin
          for (int s = 0; s < lim; s++) begin
            if (!found && !used_slots[s]) begin
              found         = 1'b1;
              used_slots[s] = 1'b1;
              res = '{ST_OK, s[SNUM_W-1:0], slot_offset(s)};
            end
          end
          if (!found) res.status = ST_FULL;
        end
        KIND_CLEAR: used_slots = '0;
        default: begin
          if (idx >= lim) res.status = ST_RANGE;
          else if (!used_slots[idx]) res.status = ST_UNUSED;
          else begin
            if (kind == KIND_FREE) used_slots[idx] = 1'b0;
            res = '{ST_OK, idx[SNUM_W-1:0], slot_offset(idx)};
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [STAT_W-1:0] status, logic [SNUM_W-1:0] slot_number,
                      logic [BOFF_W-1:0] byte_offset);
      slot_result_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d slot %0d offset %0d",
                                  status, slot_number, byte_offset));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || slot_number !== want.slot_number ||
            byte_offset !== want.byte_offset)
          report_mismatch($sformatf("got status %0d slot %0d offset %0d, want %0d %0d %0d",
                                    status, slot_number, byte_offset,
                                    want.status, want.slot_number, want.byte_offset));
      end
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  bit                    quiet_phase = 1'b0;  // both sides run flat out
  int unsigned           cycle_count = 0;

  slot_map_scoreboard sb = new();

  psba_in_if  in_chan ();
  psba_out_if out_chan ();

  page_slot_bitmap_allocator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan.sink),
    .out_chan  (out_chan.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short idle stretches, a few long ones
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(0, 2);
    if (pick < 95) return $urandom_range(3, 9);
    return $urandom_range(15, 40);
  endfunction

  // offer one request beat and hold it until the block takes it;
  // valid stays high afterwards so back-to-back beats need no second drive
  task automatic send_request(input kind_t kind, input logic [IDX_W-1:0] idx);
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= kind;
    in_chan.slot_index <= idx;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_request(kind, idx);
  endtask

  // random gap on the request side, none at all in a quiet phase
  task automatic sender_gap();
    int unsigned n;
    n = 0;
    if (!quiet_phase && $urandom_range(0, 99) >= 55) n = idle_length();
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering until every owed result has come back, then let the pipe settle
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // program all three registers plus a stray write to the unused index; only when idle
  task automatic program_config(input logic [CFG_DATA_W-1:0] count,
                                input logic [CFG_DATA_W-1:0] size,
                                input logic [CFG_DATA_W-1:0] start);
    logic [CFG_IDX_W-1:0]  idx_list  [4];
    logic [CFG_DATA_W-1:0] data_list [4];
    idx_list  = '{CFG_SLOT_COUNT, CFG_RECORD_SIZE, CFG_RECORDS_START, CFG_UNMAPPED};
    data_list = '{count, size, start, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= data_list[i];
      @(posedge clk);
      sb.write_register(idx_list[i], data_list[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // random requests with the given mix; slot indexes near the usable range but for a wide_pct share
  task automatic run_random_phase(input int unsigned n_items, input int unsigned alloc_pct,
                                  input int unsigned free_pct, input int unsigned locate_pct,
                                  input int unsigned wide_pct);
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    int unsigned      pick;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) kind = KIND_ALLOC;
      else if (pick < alloc_pct + free_pct) kind = KIND_FREE;
      else if (pick < alloc_pct + free_pct + locate_pct) kind = KIND_LOCATE;
      else kind = KIND_CLEAR;
      if ($urandom_range(0, 99) < wide_pct) idx = IDX_W'($urandom_range(0, IDX_TOP));
      else idx = IDX_W'($urandom_range(0, sb.usable_limit() + 1));
      send_request(kind, idx);
      // now and then the sender waits until the block has answered everything
      if ($urandom_range(0, 199) == 0) wait_for_drain();
      else sender_gap();
    end
    wait_for_drain();
  endtask

  // result side: takes beats, checks them and varies ready on its own
  initial begin : result_sink
    int unsigned hold;
    bit          long_stall_done;
    hold            = 0;
    long_stall_done = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        sb.check_result(out_chan.status, out_chan.slot_number, out_chan.byte_offset);
      if (!long_stall_done && sb.results_checked >= LONG_STALL_AT) begin
        // long hold-off while requests keep coming, so the block backs up
        long_stall_done = 1'b1;
        out_chan.ready <= 1'b0;
        hold            = LONG_STALL_CYCLES;
      end else if (hold > 0) begin
        hold--;
      end else if (quiet_phase || out_chan.ready !== 1'b1) begin
        out_chan.ready <= 1'b1;
        hold            = quiet_phase ? 0 : $urandom_range(0, 12);
      end else begin
        out_chan.ready <= 1'b0;
        hold            = idle_length();
      end
    end
  end

  initial begin : stimulus
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= KIND_ALLOC;
    in_chan.slot_index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: no usable slot at all
    send_request(KIND_ALLOC, '0);           // page full
    send_request(KIND_FREE, '0);            // out of range
    send_request(KIND_LOCATE, IDX_W'(IDX_TOP));
    send_request(KIND_CLEAR, '0);
    wait_for_drain();

    // eight slots of maximum size from the last byte, so offsets wrap round the page
    program_config(12'd8, 12'd4095, 12'd4095);
    repeat (8) send_request(KIND_ALLOC, IDX_W'($urandom_range(0, IDX_TOP)));
    send_request(KIND_ALLOC, '0);           // page full, map unchanged
    send_request(KIND_LOCATE, 10'd7);
    send_request(KIND_FREE, 10'd3);         // freed slot comes back with its offset
    send_request(KIND_LOCATE, 10'd3);       // now unused
    send_request(KIND_FREE, 10'd3);         // unused
    send_request(KIND_LOCATE, 10'd8);       // first slot past the limit
    send_request(KIND_FREE, IDX_W'(IDX_TOP));
    send_request(KIND_ALLOC, '0);           // lowest free slot is the hole at 3
    send_request(KIND_CLEAR, 10'h2AA);
    send_request(KIND_LOCATE, '0);          // cleared
    send_request(KIND_FREE, 10'h155);
    wait_for_drain();

    // count above capacity acts as the full page; allocate-heavy so it fills up
    program_config(12'd1023, CFG_DATA_W'($urandom_range(0, 4095)),
                   CFG_DATA_W'($urandom_range(0, 4095)));
    run_random_phase(600, 95, 2, 3, 30);

    program_config(12'd0, 12'd0, 12'd0);
    run_random_phase(30, 40, 25, 25, 50);

    program_config(12'd1, 12'd4095, 12'd0);
    run_random_phase(60, 40, 25, 30, 10);

    program_config(12'd5, CFG_DATA_W'($urandom_range(0, 4095)),
                   CFG_DATA_W'($urandom_range(0, 4095)));
    run_random_phase(110, 40, 25, 30, 10);

    program_config(12'd16, CFG_DATA_W'($urandom_range(1, 4094)), 12'd4095);
    run_random_phase(140, 45, 25, 25, 10);

    program_config(12'd512, 12'd0, CFG_DATA_W'($urandom_range(0, 4095)));
    run_random_phase(60, 50, 20, 25, 40);

    program_config(12'd513, CFG_DATA_W'($urandom_range(0, 4095)),
                   CFG_DATA_W'($urandom_range(0, 4095)));
    run_random_phase(40, 50, 20, 25, 40);

    // no idling on either side
    quiet_phase = 1'b1;
    program_config(CFG_DATA_W'($urandom_range(2, 40)), CFG_DATA_W'($urandom_range(0, 4095)),
                   CFG_DATA_W'($urandom_range(0, 4095)));
    run_random_phase(180, 45, 25, 25, 15);
    quiet_phase = 1'b0;

    wait_for_drain();
    if (sb.pending_results.size() != 0) sb.report_mismatch("results never arrived");
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
